// ----- rtl/csp_pkg.sv -----
package csp_pkg;

   localparam int COORD_BITS = 24;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int SIDE_W     = DIFF_W + 1;
   localparam int RAD_W      = 2 * SIDE_W;
   localparam int CROSS_W    = 2 * DIFF_W + 1;
   localparam int MULA_W     = (SIDE_W > 16) ? SIDE_W : 16;
   localparam int MULB_W     = (SIDE_W > 32) ? SIDE_W : 32;
   localparam int PROD_W     = MULA_W + MULB_W;
   localparam int DEN_W      = 3 * SIDE_W;
   localparam int NUM_W      = 3 * SIDE_W + 32;
   localparam int SQ_CNT_W   = $clog2(SIDE_W + 1);
   localparam int SPEED_W    = 15;
   localparam int FACTOR_W   = 16;
   localparam int K_W        = 32;
   localparam int Q_W        = 15;
   localparam int DIV_CNT_W  = $clog2(Q_W + 1);
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   localparam logic [SPEED_W-1:0]  FULL_SPEED  = 15'd25600;
   localparam logic [FACTOR_W-1:0] SPEED_SCALE = 16'd51200;

   localparam logic [CSR_IDX_W-1:0] REG_MIN_SPEED    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_CURVE_FACTOR = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL,
      ST_ACC,
      ST_SQ_GO,
      ST_SQ_WAIT,
      ST_DIV0,
      ST_DIV_STEP,
      ST_SPEED,
      ST_PUT_RES,
      ST_PUT_FIN,
      ST_ADVANCE
   } state_type;

   typedef enum logic [3:0] {
      OP_AX2,
      OP_AY2,
      OP_BX2,
      OP_BY2,
      OP_CX2,
      OP_CY2,
      OP_M1,
      OP_M2,
      OP_K,
      OP_NLO,
      OP_NHI,
      OP_AB,
      OP_DLO,
      OP_DHI
   } op_type;

endpackage

// ----- rtl/csp_isqrt.sv -----
module csp_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        sqrt_start,
   input  logic [csp_pkg::RAD_W-1:0]   sqrt_rad,
   output logic                        sqrt_done,
   output logic [csp_pkg::SIDE_W-1:0]  sqrt_root
);
   import csp_pkg::*;

   logic                busy_ff;
   logic                done_ff;
   logic [SQ_CNT_W-1:0] cnt_ff;
   logic [RAD_W-1:0]    rad_ff;
   logic [SIDE_W+1:0]   rem_ff;
   logic [SIDE_W-1:0]   root_ff;
   logic [SIDE_W+1:0]   rem_sh;
   logic [SIDE_W+1:0]   trial;
   logic                take;

   // one root bit per cycle, restoring
   always_comb begin
      rem_sh = {rem_ff[SIDE_W-1:0], rad_ff[RAD_W-1 -: 2]};
      trial  = {root_ff, 2'b01};
      take   = (rem_sh >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (sqrt_start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= SQ_CNT_W'(SIDE_W);
            rad_ff  <= sqrt_rad;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
            rem_ff  <= take ? (rem_sh - trial) : rem_sh;
            root_ff <= {root_ff[SIDE_W-2:0], take};
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == SQ_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign sqrt_done = done_ff;
   assign sqrt_root = root_ff;

endmodule

// ----- rtl/curvature_speed_profile.sv -----
// channel | dir | handshake            | payload
// req     | in  | req_valid/req_stall  | req_point_x, req_point_y, req_path_end
// rsp     | out | rsp_valid/rsp_stall  | rsp_speed, rsp_degenerate, rsp_final_point
// csr     | in  | csr_write            | csr_index, csr_data
//
// A point with three predecessors in its path takes three serial square roots, 14
// passes through the shared multiplier, then a 15-step restoring divide; a zero
// side ends it after the roots and a big quotient skips the divide. Reset is
// synchronous, active-high; it clears control, point history and min_speed and
// sets curve_factor to 256. req_stall is high while an item is in work; the output
// register lets the next item be accepted while the last result waits on rsp_stall.
module curvature_speed_profile (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [csp_pkg::COORD_BITS-1:0]   req_point_x,
   input  logic signed [csp_pkg::COORD_BITS-1:0]   req_point_y,
   input  logic                                    req_path_end,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [csp_pkg::SPEED_W-1:0]             rsp_speed,
   output logic                                    rsp_degenerate,
   output logic                                    rsp_final_point,
   input  logic                                    csr_write,
   input  logic [csp_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [csp_pkg::CSR_DATA_W-1:0]          csr_data
);
   import csp_pkg::*;

   state_type state_ff, state_in;
   op_type    op_ff;

   logic [SPEED_W-1:0]  min_speed_ff;
   logic [FACTOR_W-1:0] curve_factor_ff;

   logic signed [COORD_BITS-1:0] older_x_ff, older_y_ff, prior_x_ff, prior_y_ff;
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_y_ff;
   logic [1:0]                   seen_ff;
   logic                         last_ff;

   logic [DIFF_W-1:0] mag_ux_ff, mag_uy_ff, mag_vx_ff, mag_vy_ff, mag_wx_ff, mag_wy_ff;
   logic              sgn1_ff, sgn2_ff;

   logic [MULA_W-1:0]     mul_a;
   logic [MULB_W-1:0]     mul_b;
   logic [PROD_W-1:0]     prod_ff;
   logic [RAD_W-1:0]      rad_ff;
   logic [SIDE_W-1:0]     side_a_ff, side_b_ff, side_c_ff;
   logic [2*DIFF_W-1:0]   m1_ff;
   logic [CROSS_W-1:0]    cross_ff, cross_in;
   logic [K_W-1:0]        k_ff;
   logic [NUM_W-1:0]      num_ff, dsh_ff, den_x15;
   logic [2*SIDE_W-1:0]   ab_ff;
   logic [DEN_W-1:0]      den_ff;
   logic [Q_W-1:0]        q_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic [SPEED_W-1:0]    res_speed_ff, base_speed;
   logic                  res_deg_ff;

   logic rsp_valid_ff, rsp_degenerate_ff, rsp_final_point_ff;
   logic [SPEED_W-1:0] rsp_speed_ff;

   logic sqrt_start, sqrt_done, out_free, accept, sides_zero, big_quot, sq_op;
   logic [SIDE_W-1:0] sqrt_root;

   logic signed [DIFF_W-1:0] ux, uy, vx, vy, wx, wy;

   csp_isqrt u_isqrt (
      .clock      (clock),
      .reset      (reset),
      .sqrt_start (sqrt_start),
      .sqrt_rad   (rad_ff),
      .sqrt_done  (sqrt_done),
      .sqrt_root  (sqrt_root)
   );

   // edge vectors: u = prior-older, v = cur-older, w = cur-prior
   always_comb begin
      ux = DIFF_W'(prior_x_ff) - DIFF_W'(older_x_ff);
      uy = DIFF_W'(prior_y_ff) - DIFF_W'(older_y_ff);
      vx = DIFF_W'(cur_x_ff) - DIFF_W'(older_x_ff);
      vy = DIFF_W'(cur_y_ff) - DIFF_W'(older_y_ff);
      wx = DIFF_W'(cur_x_ff) - DIFF_W'(prior_x_ff);
      wy = DIFF_W'(cur_y_ff) - DIFF_W'(prior_y_ff);
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (op_ff)
         OP_AX2: begin mul_a = MULA_W'(mag_ux_ff); mul_b = MULB_W'(mag_ux_ff); end
         OP_AY2: begin mul_a = MULA_W'(mag_uy_ff); mul_b = MULB_W'(mag_uy_ff); end
         OP_BX2: begin mul_a = MULA_W'(mag_wx_ff); mul_b = MULB_W'(mag_wx_ff); end
         OP_BY2: begin mul_a = MULA_W'(mag_wy_ff); mul_b = MULB_W'(mag_wy_ff); end
         OP_CX2: begin mul_a = MULA_W'(mag_vx_ff); mul_b = MULB_W'(mag_vx_ff); end
         OP_CY2: begin mul_a = MULA_W'(mag_vy_ff); mul_b = MULB_W'(mag_vy_ff); end
         OP_M1:  begin mul_a = MULA_W'(mag_ux_ff); mul_b = MULB_W'(mag_vy_ff); end
         OP_M2:  begin mul_a = MULA_W'(mag_uy_ff); mul_b = MULB_W'(mag_vx_ff); end
         OP_K:   begin mul_a = MULA_W'(SPEED_SCALE); mul_b = MULB_W'(curve_factor_ff); end
         OP_NLO: begin mul_a = MULA_W'(cross_ff[SIDE_W-1:0]); mul_b = MULB_W'(k_ff); end
         OP_NHI: begin mul_a = MULA_W'(cross_ff[CROSS_W-1:SIDE_W]); mul_b = MULB_W'(k_ff); end
         OP_AB:  begin mul_a = MULA_W'(side_a_ff); mul_b = MULB_W'(side_b_ff); end
         OP_DLO: begin mul_a = MULA_W'(ab_ff[SIDE_W-1:0]); mul_b = MULB_W'(side_c_ff); end
         OP_DHI: begin mul_a = MULA_W'(ab_ff[2*SIDE_W-1:SIDE_W]); mul_b = MULB_W'(side_c_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      logic [2*DIFF_W-1:0] m2;
      m2 = prod_ff[2*DIFF_W-1:0];
      if (sgn1_ff == sgn2_ff) begin
         cross_in = (m1_ff >= m2) ? CROSS_W'(m1_ff - m2) : CROSS_W'(m2 - m1_ff);
      end else begin
         cross_in = CROSS_W'(m1_ff) + CROSS_W'(m2);
      end
   end

   always_comb begin
      sq_op      = (op_ff == OP_AY2) || (op_ff == OP_BY2) || (op_ff == OP_CY2);
      sides_zero = (side_a_ff == '0) || (side_b_ff == '0) || (sqrt_root == '0);
      den_x15    = NUM_W'(den_ff) << Q_W;
      big_quot   = (num_ff >= den_x15);
      base_speed = (q_ff >= FULL_SPEED) ? '0 : (FULL_SPEED - q_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (seen_ff == 2'd3)       state_in = ST_DIFF;
               else if (seen_ff != 2'd0)  state_in = ST_PUT_RES;
               else if (req_path_end)     state_in = ST_PUT_FIN;
               else                       state_in = ST_ADVANCE;
            end
         end
         ST_DIFF: state_in = ST_MUL;
         ST_MUL:  state_in = ST_ACC;
         ST_ACC: begin
            if (sq_op)                 state_in = ST_SQ_GO;
            else if (op_ff == OP_DHI)  state_in = ST_DIV0;
            else                       state_in = ST_MUL;
         end
         ST_SQ_GO: state_in = ST_SQ_WAIT;
         ST_SQ_WAIT: begin
            if (sqrt_done) begin
               if (op_ff == OP_CY2 && sides_zero) state_in = ST_PUT_RES;
               else                               state_in = ST_MUL;
            end
         end
         ST_DIV0:     state_in = big_quot ? ST_PUT_RES : ST_DIV_STEP;
         ST_DIV_STEP: if (div_cnt_ff == DIV_CNT_W'(1)) state_in = ST_SPEED;
         ST_SPEED:    state_in = ST_PUT_RES;
         ST_PUT_RES:  if (out_free) state_in = last_ff ? ST_PUT_FIN : ST_ADVANCE;
         ST_PUT_FIN:  if (out_free) state_in = ST_IDLE;
         ST_ADVANCE:  state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      accept     = req_valid && (state_ff == ST_IDLE);
      sqrt_start = (state_ff == ST_SQ_GO);
      out_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         op_ff           <= OP_AX2;
         min_speed_ff    <= '0;
         curve_factor_ff <= FACTOR_W'(256);
         older_x_ff      <= '0;
         older_y_ff      <= '0;
         prior_x_ff      <= '0;
         prior_y_ff      <= '0;
         seen_ff         <= '0;
         last_ff         <= 1'b0;
         div_cnt_ff      <= '0;
      end else begin
         state_ff <= state_in;

         if (csr_write) begin
            unique case (csr_index)
               REG_MIN_SPEED:    min_speed_ff    <= csr_data[SPEED_W-1:0];
               REG_CURVE_FACTOR: curve_factor_ff <= csr_data[FACTOR_W-1:0];
               default: ;
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cur_x_ff     <= req_point_x;
                  cur_y_ff     <= req_point_y;
                  last_ff      <= req_path_end;
                  res_speed_ff <= min_speed_ff;
                  res_deg_ff   <= 1'b0;
               end
            end
            ST_DIFF: begin
               op_ff     <= OP_AX2;
               mag_ux_ff <= ux[DIFF_W-1] ? -ux : ux;
               mag_uy_ff <= uy[DIFF_W-1] ? -uy : uy;
               mag_vx_ff <= vx[DIFF_W-1] ? -vx : vx;
               mag_vy_ff <= vy[DIFF_W-1] ? -vy : vy;
               mag_wx_ff <= wx[DIFF_W-1] ? -wx : wx;
               mag_wy_ff <= wy[DIFF_W-1] ? -wy : wy;
               sgn1_ff   <= ux[DIFF_W-1] ^ vy[DIFF_W-1];
               sgn2_ff   <= uy[DIFF_W-1] ^ vx[DIFF_W-1];
            end
            ST_MUL: prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
            ST_ACC: begin
               unique case (op_ff)
                  OP_AX2, OP_BX2, OP_CX2: rad_ff <= prod_ff[RAD_W-1:0];
                  OP_AY2, OP_BY2, OP_CY2: rad_ff <= rad_ff + prod_ff[RAD_W-1:0];
                  OP_M1:  m1_ff    <= prod_ff[2*DIFF_W-1:0];
                  OP_M2:  cross_ff <= cross_in;
                  OP_K:   k_ff     <= prod_ff[K_W-1:0];
                  OP_NLO: num_ff   <= NUM_W'(prod_ff);
                  OP_NHI: num_ff   <= num_ff + (NUM_W'(prod_ff) << SIDE_W);
                  OP_AB:  ab_ff    <= prod_ff[2*SIDE_W-1:0];
                  OP_DLO: den_ff   <= DEN_W'(prod_ff[2*SIDE_W-1:0]);
                  OP_DHI: den_ff   <= den_ff + (DEN_W'(prod_ff[2*SIDE_W-1:0]) << SIDE_W);
                  default: ;
               endcase
               if (!sq_op && op_ff != OP_DHI) op_ff <= op_type'(op_ff + 4'd1);
            end
            ST_SQ_GO: ;
            ST_SQ_WAIT: begin
               if (sqrt_done) begin
                  unique case (op_ff)
                     OP_AY2: side_a_ff <= sqrt_root;
                     OP_BY2: side_b_ff <= sqrt_root;
                     OP_CY2: side_c_ff <= sqrt_root;
                     default: ;
                  endcase
                  if (op_ff == OP_CY2 && sides_zero) begin
                     res_deg_ff <= 1'b1;
                  end else begin
                     op_ff <= op_type'(op_ff + 4'd1);
                  end
               end
            end
            ST_DIV0: begin
               dsh_ff     <= NUM_W'(den_ff) << (Q_W - 1);
               q_ff       <= '0;
               div_cnt_ff <= DIV_CNT_W'(Q_W);
            end
            ST_DIV_STEP: begin
               if (num_ff >= dsh_ff) begin
                  num_ff <= num_ff - dsh_ff;
                  q_ff   <= {q_ff[Q_W-2:0], 1'b1};
               end else begin
                  q_ff   <= {q_ff[Q_W-2:0], 1'b0};
               end
               dsh_ff     <= dsh_ff >> 1;
               div_cnt_ff <= div_cnt_ff - 1'b1;
            end
            ST_SPEED: begin
               res_speed_ff <= (base_speed > min_speed_ff) ? base_speed : min_speed_ff;
            end
            ST_PUT_RES: ;
            ST_PUT_FIN: begin
               if (out_free) begin
                  older_x_ff <= '0;
                  older_y_ff <= '0;
                  prior_x_ff <= '0;
                  prior_y_ff <= '0;
                  seen_ff    <= '0;
               end
            end
            ST_ADVANCE: begin
               older_x_ff <= prior_x_ff;
               older_y_ff <= prior_y_ff;
               prior_x_ff <= cur_x_ff;
               prior_y_ff <= cur_y_ff;
               if (seen_ff != 2'd3) seen_ff <= seen_ff + 2'd1;
            end
            default: ;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_PUT_RES && out_free) begin
         rsp_valid_ff       <= 1'b1;
         rsp_speed_ff       <= res_speed_ff;
         rsp_degenerate_ff  <= res_deg_ff;
         rsp_final_point_ff <= 1'b0;
      end else if (state_ff == ST_PUT_FIN && out_free) begin
         rsp_valid_ff       <= 1'b1;
         rsp_speed_ff       <= '0;
         rsp_degenerate_ff  <= 1'b0;
         rsp_final_point_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_speed       = rsp_speed_ff;
   assign rsp_degenerate  = rsp_degenerate_ff;
   assign rsp_final_point = rsp_final_point_ff;

endmodule

// ----- rtl/csp_checker.sv -----
module csp_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_stall,
   input logic signed [csp_pkg::COORD_BITS-1:0]   req_point_x,
   input logic signed [csp_pkg::COORD_BITS-1:0]   req_point_y,
   input logic                                    req_path_end,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic [csp_pkg::SPEED_W-1:0]             rsp_speed,
   input logic                                    rsp_degenerate,
   input logic                                    rsp_final_point,
   input logic                                    csr_write,
   input logic [csp_pkg::CSR_IDX_W-1:0]           csr_index,
   input logic [csp_pkg::CSR_DATA_W-1:0]          csr_data
);
   import csp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_speed)
         && $stable(rsp_degenerate) && $stable(rsp_final_point)))
      else $error("rsp item changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("req taken again right after an item");

   a_final_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_final_point) |-> (rsp_speed == '0 && !rsp_degenerate))
      else $error("final item with nonzero speed or degenerate");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind curvature_speed_profile csp_checker u_csp_checker (.*);

// ----- bench/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import csp_pkg::*;

   localparam int LIMIT   = 3000000;
   localparam int SETTLE  = 200;
   localparam int N_RAND  = 760;

   typedef struct {
      logic [SPEED_W-1:0] speed;
      logic               degenerate;
      logic               fin;
   } speed_rec_type;

   class speed_board;
      speed_rec_type       pending_q[$];
      logic [SPEED_W-1:0]  min_spd;
      logic [FACTOR_W-1:0] factor;
      longint              old_x, old_y, pre_x, pre_y;
      int                  seen;
      int                  errors, items, results;

      function new();
         min_spd = '0;
         factor  = 16'd256;
         old_x = 0; old_y = 0; pre_x = 0; pre_y = 0;
         seen = 0; errors = 0; items = 0; results = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
         if (idx == REG_MIN_SPEED) min_spd = d[SPEED_W-1:0];
         else factor = d;
      endfunction

      function longint side_len(longint x0, longint y0, longint x1, longint y1);
         logic [127:0] dx, dy, s, c, r;
         dx = (x1 >= x0) ? 128'(x1 - x0) : 128'(x0 - x1);
         dy = (y1 >= y0) ? 128'(y1 - y0) : 128'(y0 - y1);
         s = dx * dx + dy * dy;
         r = '0;
         for (int b = 34; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= s) r = c;
         end
         return longint'(r);
      endfunction

      function speed_rec_type curve(longint cx, longint cy);
         speed_rec_type e;
         longint        a, b, c, cr;
         logic [127:0]  num, den, base;
         a  = side_len(old_x, old_y, pre_x, pre_y);
         b  = side_len(pre_x, pre_y, cx, cy);
         c  = side_len(cx, cy, old_x, old_y);
         e.fin = 1'b0;
         e.degenerate = 1'b0;
         if (a == 0 || b == 0 || c == 0) begin
            e.degenerate = 1'b1;
            e.speed = min_spd;
            return e;
         end
         cr = (pre_x - old_x) * (cy - old_y) - (pre_y - old_y) * (cx - old_x);
         if (cr < 0) cr = -cr;
         num = 128'(cr) * 128'(factor) * 128'd51200;
         den = 128'(a) * 128'(b) * 128'(c);
         if (num >= den * 128'd25600) base = '0;
         else base = 128'd25600 - num / den;
         e.speed = (base > 128'(min_spd)) ? base[SPEED_W-1:0] : min_spd;
         return e;
      endfunction

      function void note_point(logic signed [COORD_BITS-1:0] x,
                               logic signed [COORD_BITS-1:0] y, logic last);
         speed_rec_type e;
         longint cx, cy;
         cx = longint'(x); cy = longint'(y);
         items++;
         if (seen >= 1) begin
            if (seen >= 3) e = curve(cx, cy);
            else begin
               e.speed = min_spd; e.degenerate = 1'b0; e.fin = 1'b0;
            end
            pending_q = {pending_q, e};
         end
         if (last) begin
            e.speed = '0; e.degenerate = 1'b0; e.fin = 1'b1;
            pending_q = {pending_q, e};
            old_x = 0; old_y = 0; pre_x = 0; pre_y = 0; seen = 0;
         end else begin
            old_x = pre_x; old_y = pre_y; pre_x = cx; pre_y = cy;
            if (seen < 3) seen++;
         end
      endfunction

      function void check_speed(logic [SPEED_W-1:0] spd, logic deg, logic fin);
         speed_rec_type e;
         results++;
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected item: speed %0d deg %0d fin %0d",
                                       spd, deg, fin);
            return;
         end
         e = pending_q.pop_front();
         if (spd !== e.speed || deg !== e.degenerate || fin !== e.fin) begin
            errors++;
            if (errors <= 10)
               $display("item %0d: expected speed %0d deg %0d fin %0d, got %0d %0d %0d",
                        results, e.speed, e.degenerate, e.fin, spd, deg, fin);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [COORD_BITS-1:0] req_point_x = '0;
   logic signed [COORD_BITS-1:0] req_point_y = '0;
   logic req_path_end = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [SPEED_W-1:0] rsp_speed;
   logic rsp_degenerate;
   logic rsp_final_point;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   speed_board board = new();
   bit     idle_on = 1;
   bit     hold_req = 0;
   int     hold_cnt = 0;
   int     cycles = 0;
   int     paths = 0;
   logic signed [COORD_BITS-1:0] cur_x = '0, cur_y = '0;

   curvature_speed_profile dut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("curvature_speed_profile: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else begin
         if (hold_req) begin
            hold_cnt = 400;
            hold_req = 0;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_stall <= 1'b1;
         end else
            rsp_stall <= idle_on && ($urandom_range(99) < 10);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         board.check_speed(rsp_speed, rsp_degenerate, rsp_final_point);

   task automatic send(int x, int y, logic last);
      while (idle_on && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_point_x  <= COORD_BITS'(x);
      req_point_y  <= COORD_BITS'(y);
      req_path_end <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_point(COORD_BITS'(x), COORD_BITS'(y), last);
      if (last) paths++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      board.write_reg(idx, d);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic directed_paths();
      send(8388607, -8388608, 1'b1);
      send(0, 0, 1'b0); send(256, 0, 1'b1);
      send(0, 0, 1'b0); send(256, 0, 1'b0); send(512, 0, 1'b0); send(768, 0, 1'b1);
      send(100, 100, 1'b0); send(100, 100, 1'b0); send(100, 100, 1'b0);
      send(200, 200, 1'b1);
      send(-8388608, -8388608, 1'b0); send(8388607, -8388608, 1'b0);
      send(8388607, 8388607, 1'b0); send(-8388608, 8388607, 1'b0);
      send(0, 0, 1'b1);
      send(0, 0, 1'b0); send(256, 0, 1'b0); send(0, 10, 1'b0); send(300, 5, 1'b1);
   endtask

   task automatic random_path(int len);
      int step, mode;
      mode = $urandom_range(9);
      step = (mode < 6) ? $urandom_range(2000, 1) : (mode < 8) ? 40 : 0;
      cur_x = COORD_BITS'($urandom); cur_y = COORD_BITS'($urandom);
      for (int i = 0; i < len; i++) begin
         if (mode == 9) begin
            cur_x = COORD_BITS'($urandom); cur_y = COORD_BITS'($urandom);
         end else if ($urandom_range(19) == 0) begin
            // repeat the previous point
         end else begin
            cur_x = COORD_BITS'(cur_x + $signed($urandom_range(2 * step)) - step);
            cur_y = COORD_BITS'(cur_y + $signed($urandom_range(2 * step)) - step);
         end
         send(int'(cur_x), int'(cur_y), i == len - 1);
      end
   endtask

   task automatic random_block(int n);
      int sent;
      int len;
      sent = 0;
      while (sent < n) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(14, 3);
         random_path(len);
         sent += len;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_reg(REG_MIN_SPEED, 16'd0);
      set_reg(REG_CURVE_FACTOR, 16'd256);
      directed_paths();
      drain();

      set_reg(REG_MIN_SPEED, 16'hFFFF);
      set_reg(REG_CURVE_FACTOR, 16'hFFFF);
      directed_paths();
      random_block(40);
      drain();

      set_reg(REG_MIN_SPEED, 16'd25600);
      set_reg(REG_CURVE_FACTOR, 16'd0);
      random_block(60);
      drain();

      set_reg(REG_MIN_SPEED, 16'd3000);
      set_reg(REG_CURVE_FACTOR, 16'd1024);
      idle_on = 0;
      hold_req = 1;
      random_block(150);
      idle_on = 1;
      drain();

      for (int p = 0; p < 4; p++) begin
         set_reg(REG_MIN_SPEED, CSR_DATA_W'($urandom_range(25600)));
         set_reg(REG_CURVE_FACTOR, CSR_DATA_W'($urandom_range(65535)));
         random_block(N_RAND / 5);
         drain();
      end

      $display("%0d points in %0d paths, %0d speeds checked, %0d errors",
               board.items, paths, board.results, board.errors);
      $display("register settings covered min_speed 0..32767 and curve_factor 0..65535");
      if (board.errors == 0 && board.pending_q.size() == 0)
         $display("curvature_speed_profile: match");
      else
         $display("curvature_speed_profile: mismatch");
      $finish;
   end

endmodule
